### rtl/core/base32_stream_encoder_core_assert.svh
// Assertion macros for the base32 stream encoder checker.
// Standalone; included by the checker file only.
`ifndef BASE32_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE32_STREAM_ENCODER_CORE_ASSERT_SVH

// antecedent true at an edge implies consequent at that same edge
`define B32_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// antecedent true at an edge implies consequent at the next edge
`define B32_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

### rtl/core/b32enc_pkg.sv
// Shared types, constants and helper functions for the base32 stream encoder.
// No dependencies.
package b32enc_pkg;

    localparam int unsigned GROUP_BYTES = 5;
    localparam int unsigned GROUP_HOLD  = 4;
    localparam int unsigned GROUP_CHARS = 8;
    localparam int unsigned GROUP_BITS  = GROUP_BYTES * 8;

    localparam logic [6:0] PAD_CHAR    = 7'h3D;   // '='
    localparam logic [6:0] ALPHA_BASE  = 7'h41;   // 'A'
    localparam logic [6:0] DIGIT_BASE  = 7'h32;   // '2'
    localparam logic [4:0] ALPHA_COUNT = 5'd26;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } out_item_t;

    // one closed group: five bytes MSB first, meaningful char count, final flag
    typedef struct packed {
        logic [GROUP_BITS-1:0] bits;
        logic [3:0]            ndata;
        logic                  eom;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [6:0] b32_char(input logic [4:0] sym);
        logic [6:0] ch;
        if (sym < ALPHA_COUNT)
            ch = ALPHA_BASE + {2'b00, sym};
        else
            ch = DIGIT_BASE + {2'b00, sym - ALPHA_COUNT};
        return ch;
    endfunction

    // chars carrying data for a group whose last byte lands at slot fill
    function automatic logic [3:0] chars_for_fill(input logic [2:0] fill);
        logic [3:0] n;
        unique case (fill)
            3'd0:    n = 4'd2;
            3'd1:    n = 4'd4;
            3'd2:    n = 4'd5;
            3'd3:    n = 4'd7;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

### rtl/core/b32enc_queue.sv
// Short group queue between the byte collector and the character serializer.
// Depends on b32enc_pkg.
module b32enc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b32enc_pkg::group_t  push_data,
    input  logic                pop,
    output b32enc_pkg::group_t  head,
    output b32enc_pkg::q_status_t status
);
    import b32enc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    group_t             slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slots_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/core/b32enc_front.sv
// Byte collector: holds up to four bytes and closes a group on the fifth or final byte.
// Depends on b32enc_pkg.
module b32enc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b32enc_pkg::in_item_t  in_data,
    output logic                  push,
    output b32enc_pkg::group_t    push_data,
    input  b32enc_pkg::q_status_t q_status
);
    import b32enc_pkg::*;

    logic [7:0] bytes_reg [GROUP_HOLD];
    logic [2:0] fill_reg, fill_next;
    logic [7:0] grp [GROUP_BYTES];
    logic       accept;
    logic       closes;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign closes   = (fill_reg == 3'(GROUP_HOLD)) || in_data.end_of_message;
    assign push     = accept && closes;

    // missing bytes of a short group read as zero
    always_comb
    begin
        for (int k = 0; k < GROUP_BYTES; k++)
        begin
            grp[k] = '0;
            if (k < GROUP_HOLD && 3'(k) < fill_reg)
                grp[k] = bytes_reg[2'(k)];
            if (3'(k) == fill_reg)
                grp[k] = in_data.data_byte;
        end
    end

    assign push_data.bits  = {grp[0], grp[1], grp[2], grp[3], grp[4]};
    assign push_data.ndata = chars_for_fill(fill_reg);
    assign push_data.eom   = in_data.end_of_message;

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
            fill_next = closes ? 3'd0 : fill_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !closes)
            bytes_reg[fill_reg[1:0]] <= in_data.data_byte;
    end

endmodule

### rtl/core/b32enc_back.sv
// Character serializer: a group becomes eight chars, one per cycle unless stalled.
// Depends on b32enc_pkg.
module b32enc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b32enc_pkg::group_t    head,
    input  b32enc_pkg::q_status_t q_status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b32enc_pkg::out_item_t out_data
);
    import b32enc_pkg::*;

    group_t     grp_reg, grp_next;
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic       adv, emit, load;
    logic [5:0] sym_lsb;
    logic [4:0] sym;
    out_item_t  cur;

    assign sym_lsb      = 6'({3'd0, 3'd7 - idx_reg}) * 6'd5;
    assign sym          = grp_reg.bits[sym_lsb +: 5];
    assign cur.out_char = ({1'b0, idx_reg} < grp_reg.ndata) ? b32_char(sym) : PAD_CHAR;
    assign cur.out_last = grp_reg.eom && (idx_reg == 3'(GROUP_CHARS - 1));

    assign adv  = !out_valid_reg || out_ready;
    assign emit = adv && busy_reg;
    // next group is fetched as the eighth char goes out, so chars run gap-free
    assign load = !q_status.empty
               && (!busy_reg || (emit && idx_reg == 3'(GROUP_CHARS - 1)));
    assign pop  = load;

    always_comb
    begin
        grp_next       = grp_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            idx_next       = idx_reg + 3'd1;
            out_valid_next = 1'b1;
            out_data_next  = cur;
            if (idx_reg == 3'(GROUP_CHARS - 1))
                busy_next = 1'b0;
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            grp_next  = head;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg      <= grp_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/core/base32_stream_encoder_core.sv
// Top level of the base32 stream encoder: collector, group queue, serializer.
// Depends on b32enc_pkg, b32enc_front, b32enc_queue, b32enc_back.

// Base32 (A-Z, 2-7) encoder for a byte stream. Bytes arrive one per transfer with an
// end_of_message flag; every fifth byte, or the flagged byte, closes a group that comes
// out as eight characters, with '=' in place of characters that only missing bytes
// would produce, and out_last set on the eighth character of the final group. The
// collector takes a byte every cycle while the group queue has room; the serializer
// sends one character per cycle while the output is not stalled, so the character
// serializer sets the sustained input rate. Short groups also give eight characters.
// The first character passes the queue slot, the group register and the output
// register after the closing byte is transferred. No clearing pass after reset.
module base32_stream_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b32enc_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b32enc_pkg::out_item_t out_data
);
    import b32enc_pkg::*;

    logic      push;
    logic      pop;
    group_t    push_data;
    group_t    head;
    q_status_t q_status;

    b32enc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .q_status  (q_status)
    );

    b32enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    b32enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/core/b32enc_checker.sv
// Port-level checker for the base32 stream encoder, bound to the top level.
// Depends on b32enc_pkg and base32_stream_encoder_core_assert.svh.
`include "base32_stream_encoder_core_assert.svh"

module b32enc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input b32enc_pkg::out_item_t out_data
);
    import b32enc_pkg::*;

    logic [2:0] pos_reg;
    logic       out_xfer;
    logic       legal_char;

    assign out_xfer   = out_valid && out_ready;
    assign legal_char = (out_data.out_char >= 7'h41 && out_data.out_char <= 7'h5A)
                     || (out_data.out_char >= 7'h32 && out_data.out_char <= 7'h37)
                     || (out_data.out_char == PAD_CHAR);

    // position of the next char within its 8-char group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (out_xfer)
            pos_reg <= pos_reg + 3'd1;
    end

    `B32_ASSERT_IMP(a_last_at_group_end, clk, rst_n, out_xfer && out_data.out_last, pos_reg == 3'd7, "out_last off group end")
    `B32_ASSERT_IMP(a_no_pad_in_head, clk, rst_n, out_xfer && pos_reg < 3'd2, out_data.out_char != PAD_CHAR, "pad in first two chars")
    `B32_ASSERT_IMP(a_legal_char, clk, rst_n, out_valid, legal_char, "char outside alphabet")
    `B32_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output changed")

endmodule

bind base32_stream_encoder_core b32enc_checker u_b32enc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
